>>> hdl/valu_pkg.sv
// Shared types, constants and saturation helper for the 3D vector unit.
package valu_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned ProdBits = 2 * WordBits;
  localparam int unsigned SumBits  = 2 * WordBits + 2;
  localparam int unsigned QuotBits = FracBits + 1;
  localparam int unsigned RemBits  = WordBits + 4;
  localparam int unsigned DRemBits = WordBits + 1;
  localparam int unsigned SideLat  = WordBits + QuotBits;
  localparam int unsigned PipeLat  = 2 + WordBits + QuotBits + 1;

  typedef enum logic [2:0] {
    MODE_ADD,
    MODE_SUB,
    MODE_NEG,
    MODE_CROSS,
    MODE_SCALE,
    MODE_DOT,
    MODE_LEN,
    MODE_UNIT
  } mode_e;

  typedef logic signed [WordBits-1:0] word_t;

  typedef struct packed {
    mode_e mode;
    word_t ax;
    word_t ay;
    word_t az;
    word_t bx;
    word_t by;
    word_t bz;
    word_t factor;
  } op_t;

  typedef struct packed {
    word_t rx;
    word_t ry;
    word_t rz;
    word_t scalar;
    logic  is_null;
    logic  saturated;
  } res_t;

  typedef struct packed {
    mode_e                      mode;
    word_t [2:0]                vec;
    word_t                      scalar;
    logic                       sat;
    logic [2:0][WordBits-1:0]   amag;
    logic [2:0]                 aneg;
  } side_t;

  typedef struct packed {
    word_t val;
    logic  flag;
  } sat_t;

  function automatic sat_t sat_wide(logic signed [SumBits-1:0] x);
    sat_t r;
    logic [SumBits-WordBits:0] top;
    top = x[SumBits-1:WordBits-1];
    if ((&top) || !(|top)) begin
      r.val  = x[WordBits-1:0];
      r.flag = 1'b0;
    end else begin
      r.val  = x[SumBits-1] ? {1'b1, {(WordBits-1){1'b0}}} : {1'b0, {(WordBits-1){1'b1}}};
      r.flag = 1'b1;
    end
    return r;
  endfunction

endpackage

>>> hdl/valu_mul.sv
// Operand select, product stage and combine stage of the vector unit.
module valu_mul (
  input  logic                           clk_i,
  input  valu_pkg::op_t                  op_i,
  output valu_pkg::side_t                side_o,
  output logic [valu_pkg::ProdBits-1:0]  sq_o
);

  valu_pkg::word_t                          x [6];
  valu_pkg::word_t                          y [6];
  valu_pkg::word_t                          a [3];
  valu_pkg::word_t                          b [3];
  logic signed [valu_pkg::ProdBits-1:0]     p_d [6];
  logic signed [valu_pkg::ProdBits-1:0]     p_q [6];
  logic signed [valu_pkg::WordBits:0]       ab_d [3];
  logic signed [valu_pkg::WordBits:0]       ab_q [3];
  logic [2:0][valu_pkg::WordBits-1:0]       amag_d;
  logic [2:0][valu_pkg::WordBits-1:0]       amag_q;
  logic [2:0]                               aneg_d;
  logic [2:0]                               aneg_q;
  valu_pkg::mode_e                          mode_q;
  logic signed [valu_pkg::SumBits-1:0]      w [3];
  logic signed [valu_pkg::SumBits-1:0]      wd;
  valu_pkg::sat_t                           sv [3];
  valu_pkg::sat_t                           ss;
  valu_pkg::side_t                          side_d;
  valu_pkg::side_t                          side_q;
  logic [valu_pkg::ProdBits-1:0]            sq_d;
  logic [valu_pkg::ProdBits-1:0]            sq_q;

  assign a[0] = op_i.ax;
  assign a[1] = op_i.ay;
  assign a[2] = op_i.az;
  assign b[0] = op_i.bx;
  assign b[1] = op_i.by;
  assign b[2] = op_i.bz;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      x[k] = '0;
      y[k] = '0;
    end
    unique case (op_i.mode)
      valu_pkg::MODE_CROSS: begin
        x[0] = a[1]; y[0] = b[2];
        x[1] = a[2]; y[1] = b[1];
        x[2] = a[2]; y[2] = b[0];
        x[3] = a[0]; y[3] = b[2];
        x[4] = a[0]; y[4] = b[1];
        x[5] = a[1]; y[5] = b[0];
      end
      valu_pkg::MODE_DOT: begin
        for (int k = 0; k < 3; k++) begin
          x[2*k] = a[k]; y[2*k] = b[k];
        end
      end
      valu_pkg::MODE_SCALE: begin
        for (int k = 0; k < 3; k++) begin
          x[2*k] = op_i.factor; y[2*k] = a[k];
        end
      end
      valu_pkg::MODE_LEN, valu_pkg::MODE_UNIT: begin
        for (int k = 0; k < 3; k++) begin
          x[2*k] = a[k]; y[2*k] = a[k];
        end
      end
      default: begin
      end
    endcase
    for (int k = 0; k < 6; k++) begin
      p_d[k] = valu_pkg::ProdBits'(x[k]) * valu_pkg::ProdBits'(y[k]);
    end
    for (int k = 0; k < 3; k++) begin
      unique case (op_i.mode)
        valu_pkg::MODE_ADD: ab_d[k] = (valu_pkg::WordBits+1)'(a[k])
                                    + (valu_pkg::WordBits+1)'(b[k]);
        valu_pkg::MODE_SUB: ab_d[k] = (valu_pkg::WordBits+1)'(a[k])
                                    - (valu_pkg::WordBits+1)'(b[k]);
        valu_pkg::MODE_NEG: ab_d[k] = -(valu_pkg::WordBits+1)'(a[k]);
        default:            ab_d[k] = '0;
      endcase
      aneg_d[k] = a[k][valu_pkg::WordBits-1];
      amag_d[k] = aneg_d[k] ? (~a[k] + 1'b1) : a[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 6; k++) begin
      p_q[k] <= p_d[k];
    end
    for (int k = 0; k < 3; k++) begin
      ab_q[k] <= ab_d[k];
    end
    amag_q <= amag_d;
    aneg_q <= aneg_d;
    mode_q <= op_i.mode;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (mode_q)
        valu_pkg::MODE_ADD, valu_pkg::MODE_SUB, valu_pkg::MODE_NEG:
          w[k] = valu_pkg::SumBits'(ab_q[k]);
        valu_pkg::MODE_CROSS:
          w[k] = (valu_pkg::SumBits'(p_q[2*k]) - valu_pkg::SumBits'(p_q[2*k+1]))
                 >>> valu_pkg::FracBits;
        valu_pkg::MODE_SCALE:
          w[k] = valu_pkg::SumBits'(p_q[2*k]) >>> valu_pkg::FracBits;
        default:
          w[k] = '0;
      endcase
      sv[k] = valu_pkg::sat_wide(w[k]);
    end
    wd = (valu_pkg::SumBits'(p_q[0]) + valu_pkg::SumBits'(p_q[2])
          + valu_pkg::SumBits'(p_q[4])) >>> valu_pkg::FracBits;
    ss = valu_pkg::sat_wide(wd);
    sq_d = $unsigned(p_q[0]) + $unsigned(p_q[2]) + $unsigned(p_q[4]);
    side_d.mode = mode_q;
    for (int k = 0; k < 3; k++) begin
      side_d.vec[k] = sv[k].val;
    end
    side_d.amag = amag_q;
    side_d.aneg = aneg_q;
    if (mode_q == valu_pkg::MODE_DOT) begin
      side_d.scalar = ss.val;
      side_d.sat    = ss.flag;
    end else begin
      side_d.scalar = '0;
      side_d.sat    = sv[0].flag | sv[1].flag | sv[2].flag;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_d;
    sq_q   <= sq_d;
  end

  assign side_o = side_q;
  assign sq_o   = sq_q;

endmodule

>>> hdl/valu_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module valu_sqrt (
  input  logic                           clk_i,
  input  logic [valu_pkg::ProdBits-1:0]  sq_i,
  output logic [valu_pkg::WordBits-1:0]  root_o
);

  logic [valu_pkg::RemBits-1:0]  rem_q  [valu_pkg::WordBits];
  logic [valu_pkg::WordBits-1:0] root_q [valu_pkg::WordBits];
  logic [valu_pkg::ProdBits-1:0] num_q  [valu_pkg::WordBits];

  for (genvar i = 0; i < valu_pkg::WordBits; i++) begin : g_stage
    logic [valu_pkg::RemBits-1:0]  rem_in;
    logic [valu_pkg::RemBits-1:0]  r4;
    logic [valu_pkg::RemBits-1:0]  trial;
    logic [valu_pkg::WordBits-1:0] root_in;
    logic [valu_pkg::ProdBits-1:0] num_in;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign num_in  = sq_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign num_in  = num_q[i-1];
    end

    assign r4    = {rem_in[valu_pkg::RemBits-3:0], num_in[valu_pkg::ProdBits-1 -: 2]};
    assign trial = {(valu_pkg::RemBits-2)'(root_in), 2'b01};

    always_ff @(posedge clk_i) begin
      if (r4 >= trial) begin
        rem_q[i]  <= r4 - trial;
        root_q[i] <= {root_in[valu_pkg::WordBits-2:0], 1'b1};
      end else begin
        rem_q[i]  <= r4;
        root_q[i] <= {root_in[valu_pkg::WordBits-2:0], 1'b0};
      end
      num_q[i] <= num_in << 2;
    end
  end

  assign root_o = root_q[valu_pkg::WordBits-1];

endmodule

>>> hdl/valu_div.sv
// Pipelined restoring divider lane for the unit-vector quotient.
module valu_div (
  input  logic                           clk_i,
  input  logic [valu_pkg::WordBits-1:0]  mag_i,
  input  logic [valu_pkg::WordBits-1:0]  den_i,
  output logic [valu_pkg::QuotBits-1:0]  quot_o,
  output logic [valu_pkg::WordBits-1:0]  den_o
);

  logic [valu_pkg::DRemBits-1:0] rem_q [valu_pkg::QuotBits];
  logic [valu_pkg::QuotBits-1:0] quot_q [valu_pkg::QuotBits];
  logic [valu_pkg::QuotBits-1:0] nb_q  [valu_pkg::QuotBits];
  logic [valu_pkg::WordBits-1:0] den_q [valu_pkg::QuotBits];

  for (genvar j = 0; j < valu_pkg::QuotBits; j++) begin : g_stage
    logic [valu_pkg::DRemBits-1:0] rem_in;
    logic [valu_pkg::DRemBits-1:0] r2;
    logic [valu_pkg::DRemBits-1:0] dx;
    logic [valu_pkg::QuotBits-1:0] quot_in;
    logic [valu_pkg::QuotBits-1:0] nb_in;
    logic [valu_pkg::WordBits-1:0] den_in;

    if (j == 0) begin : g_first
      assign rem_in  = valu_pkg::DRemBits'(mag_i >> 1);
      assign quot_in = '0;
      assign nb_in   = {mag_i[0], {(valu_pkg::QuotBits-1){1'b0}}};
      assign den_in  = den_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign quot_in = quot_q[j-1];
      assign nb_in   = nb_q[j-1];
      assign den_in  = den_q[j-1];
    end

    assign r2 = {rem_in[valu_pkg::DRemBits-2:0], nb_in[valu_pkg::QuotBits-1]};
    assign dx = {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (r2 >= dx) begin
        rem_q[j]  <= r2 - dx;
        quot_q[j] <= {quot_in[valu_pkg::QuotBits-2:0], 1'b1};
      end else begin
        rem_q[j]  <= r2;
        quot_q[j] <= {quot_in[valu_pkg::QuotBits-2:0], 1'b0};
      end
      nb_q[j]  <= nb_in << 1;
      den_q[j] <= den_in;
    end
  end

  assign quot_o = quot_q[valu_pkg::QuotBits-1];
  assign den_o  = den_q[valu_pkg::QuotBits-1];

endmodule

>>> hdl/vector3_alu.sv
// Top level of the pipelined 3D vector unit.
//   channel  ports                 handshake
//   item in  op_i                  start, accepted when busy is low
//   result   res_o                 valid_o, one cycle, always taken
// One item per cycle. Stages at Q16.16: product, combine, one square-root
// stage per root bit, one divider stage per quotient bit, output register.
// Reset clears only the valid bits. busy stays low: the receiver cannot stall.
module vector3_alu (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  valu_pkg::op_t   op_i,
  output valu_pkg::res_t  res_o,
  output logic            valid_o
);

  logic                          vld_q [valu_pkg::PipeLat];
  valu_pkg::side_t               front;
  logic [valu_pkg::ProdBits-1:0] sq;
  logic [valu_pkg::WordBits-1:0] root;
  valu_pkg::side_t               side_q [valu_pkg::SideLat];
  logic [valu_pkg::QuotBits-1:0] quot [3];
  logic [valu_pkg::WordBits-1:0] den [3];
  valu_pkg::side_t               sd;
  logic [valu_pkg::WordBits-1:0] len;
  logic                          null_len;
  valu_pkg::res_t                res_d;
  valu_pkg::res_t                res_q;

  assign busy = 1'b0;

  valu_mul u_mul (
    .clk_i  (clk_i),
    .op_i   (op_i),
    .side_o (front),
    .sq_o   (sq)
  );

  valu_sqrt u_sqrt (
    .clk_i  (clk_i),
    .sq_i   (sq),
    .root_o (root)
  );

  for (genvar k = 0; k < 3; k++) begin : g_lane
    valu_div u_div (
      .clk_i  (clk_i),
      .mag_i  (side_q[valu_pkg::WordBits-1].amag[k]),
      .den_i  (root),
      .quot_o (quot[k]),
      .den_o  (den[k])
    );
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= front;
    for (int i = 1; i < valu_pkg::SideLat; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < valu_pkg::PipeLat; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= start & ~busy;
      for (int i = 1; i < valu_pkg::PipeLat; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  assign sd       = side_q[valu_pkg::SideLat-1];
  assign len      = den[0];
  assign null_len = (len == '0);

  always_comb begin
    res_d.rx        = sd.vec[0];
    res_d.ry        = sd.vec[1];
    res_d.rz        = sd.vec[2];
    res_d.scalar    = sd.scalar;
    res_d.is_null   = 1'b0;
    res_d.saturated = sd.sat;
    unique case (sd.mode)
      valu_pkg::MODE_LEN: begin
        res_d.is_null   = null_len;
        res_d.saturated = len[valu_pkg::WordBits-1];
        res_d.scalar    = len[valu_pkg::WordBits-1]
                        ? {1'b0, {(valu_pkg::WordBits-1){1'b1}}} : len;
      end
      valu_pkg::MODE_UNIT: begin
        res_d.is_null = null_len;
        res_d.rx = null_len ? '0 : sd.aneg[0] ? -valu_pkg::word_t'(quot[0])
                                              : valu_pkg::word_t'(quot[0]);
        res_d.ry = null_len ? '0 : sd.aneg[1] ? -valu_pkg::word_t'(quot[1])
                                              : valu_pkg::word_t'(quot[1]);
        res_d.rz = null_len ? '0 : sd.aneg[2] ? -valu_pkg::word_t'(quot[2])
                                              : valu_pkg::word_t'(quot[2]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o   = res_q;
  assign valid_o = vld_q[valu_pkg::PipeLat-1];

endmodule

>>> tb/tb_vector3_alu.sv
// Testbench for vector3_alu: random and directed vector items checked against a Q16.16 predictor.
module tb_vector3_alu;
  timeunit 1ns;
  timeprecision 1ps;
  import valu_pkg::*;

  localparam int Latency = 60;
  localparam int WatchLimit = 2000;
  localparam int NumRandom = 1950;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  op_t op_i = '0;
  res_t res_o;
  logic valid_o;

  int errors = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  bit quiet = 1'b0;

  vector3_alu DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .op_i(op_i), .res_o(res_o), .valid_o(valid_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic word_t clamp_word(logic signed [127:0] x, ref logic flag);
    if (x > 128'sd2147483647) begin
      flag = 1'b1;
      return 32'sh7fffffff;
    end
    if (x < -128'sd2147483648) begin
      flag = 1'b1;
      return 32'sh80000000;
    end
    return word_t'(x[31:0]);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [127:0] n);
    logic [63:0] r, c;
    r = '0;
    for (int b = 48; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  function automatic res_t vector_result(op_t op);
    res_t r;
    logic signed [127:0] a[3], b[3], f, d, acc;
    logic [127:0] sq, q;
    logic [63:0] len;
    logic flag;
    r = '0;
    flag = 1'b0;
    a[0] = op.ax; a[1] = op.ay; a[2] = op.az;
    b[0] = op.bx; b[1] = op.by; b[2] = op.bz;
    f = op.factor;
    acc = '0;
    sq = '0;
    case (op.mode)
      MODE_ADD, MODE_SUB, MODE_NEG, MODE_CROSS, MODE_SCALE, MODE_UNIT: begin
        if (op.mode == MODE_UNIT) begin
          for (int i = 0; i < 3; i++) sq += a[i] * a[i];
          len = floor_sqrt(sq);
          r.is_null = (len == 0);
        end
        for (int i = 0; i < 3; i++) begin
          case (op.mode)
            MODE_ADD: d = a[i] + b[i];
            MODE_SUB: d = a[i] - b[i];
            MODE_NEG: d = -a[i];
            MODE_CROSS: d = (a[(i+1)%3] * b[(i+2)%3] - a[(i+2)%3] * b[(i+1)%3]) >>> FracBits;
            MODE_SCALE: d = (f * a[i]) >>> FracBits;
            default: begin
              if (len == 0) d = '0;
              else begin
                q = ((a[i] < 0 ? -a[i] : a[i]) << FracBits) / {64'd0, len};
                d = (a[i] < 0) ? -$signed(q) : $signed(q);
              end
            end
          endcase
          if (i == 0) r.rx = clamp_word(d, flag);
          else if (i == 1) r.ry = clamp_word(d, flag);
          else r.rz = clamp_word(d, flag);
        end
      end
      MODE_DOT: begin
        for (int i = 0; i < 3; i++) acc += a[i] * b[i];
        r.scalar = clamp_word(acc >>> FracBits, flag);
      end
      default: begin
        for (int i = 0; i < 3; i++) sq += a[i] * a[i];
        len = floor_sqrt(sq);
        r.is_null = (len == 0);
        r.scalar = clamp_word($signed({64'd0, len}), flag);
      end
    endcase
    r.saturated = flag;
    return r;
  endfunction

  class result_board;
    res_t pending[$];

    function void note_item(op_t op);
      pending.push_back(vector_result(op));
    endfunction

    task check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.rx !== want.rx) report_mismatch("rx", got.rx, want.rx);
      if (got.ry !== want.ry) report_mismatch("ry", got.ry, want.ry);
      if (got.rz !== want.rz) report_mismatch("rz", got.rz, want.rz);
      if (got.scalar !== want.scalar) report_mismatch("scalar", got.scalar, want.scalar);
      if (got.is_null !== want.is_null) report_mismatch("is_null", got.is_null, want.is_null);
      if (got.saturated !== want.saturated)
        report_mismatch("saturated", got.saturated, want.saturated);
    endtask
  endclass

  result_board board = new();

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) board.note_item(op_i);
      if (valid_o) board.check_result(res_o);
      if ((start && !busy) || valid_o || board.pending.size() == 0) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WatchLimit);
    $display("Verification failed");
    $finish;
  end

  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return word_t'($urandom_range(0, 131071)) - 32'sd65536;
      4, 5: return word_t'($urandom_range(0, 16777215)) - 32'sd8388608;
      default: return word_t'($urandom());
    endcase
  endfunction

  // hold the item until accepted, then advance
  task automatic send_item(op_t op);
    start <= 1'b1;
    op_i <= op;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic send_fields(mode_e m, word_t x, word_t y, word_t z, word_t f);
    op_t op;
    op = '{mode: m, ax: x, ay: y, az: z, bx: y, by: z, bz: x, factor: f};
    send_item(op);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    op_t op;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int m = 0; m < 8; m++) begin
      send_fields(mode_e'(m), 32'sh7fffffff, 32'sh80000000, 32'sh00010000, 32'sh80000000);
      send_fields(mode_e'(m), '0, '0, '0, 32'sh7fffffff);
    end
    send_fields(MODE_UNIT, 32'sh00000001, '0, '0, '0);
    send_fields(MODE_LEN, 32'sh80000000, 32'sh80000000, 32'sh80000000, '0);
    send_fields(MODE_UNIT, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, '0);
    send_fields(MODE_NEG, 32'sh80000000, 32'sh80000000, 32'sh80000000, '0);
    send_fields(MODE_SCALE, 32'sh00030000, 32'shfffd0000, 32'sh00008000, 32'shffff0000);
    drain();
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) drain();
      if (n == NumRandom - 300) quiet = 1'b1;
      op.mode = mode_e'($urandom_range(0, 7));
      op.ax = pick_word(); op.ay = pick_word(); op.az = pick_word();
      op.bx = pick_word(); op.by = pick_word(); op.bz = pick_word();
      op.factor = pick_word();
      send_item(op);
    end
    drain();
    repeat (Latency) @(posedge clk_i);
    $display("Sent %0d items over all eight modes, including field extremes,", items_sent);
    $display("zero vectors and sender gaps with the result stream never stalled.");
    if (errors == 0 && board.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

>>> vector3_alu.f
hdl/valu_pkg.sv
hdl/valu_mul.sv
hdl/valu_sqrt.sv
hdl/valu_div.sv
hdl/vector3_alu.sv
tb/tb_vector3_alu.sv
